// ===== src/permen_pkg.sv =====
// Shared types and constants of the permutation enumerator.
`default_nettype none

package permen_pkg;

   localparam int SYM_W     = 8;
   localparam int SLOT_W    = 3;
   localparam int SIZE_W    = 4;
   localparam int CNT_W     = 3;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd4;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_NEXT = 1'b1;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_PIVOT = 10'b0000000010,
      ST_EMIT  = 10'b0000000100,
      ST_EMPTY = 10'b0000001000,
      ST_FIND  = 10'b0000010000,
      ST_SWAP1 = 10'b0000100000,
      ST_SWAP2 = 10'b0001000000,
      ST_REVA  = 10'b0010000000,
      ST_REVB  = 10'b0100000000,
      ST_REVC  = 10'b1000000000
   } state_type;

   typedef struct packed {
      logic             we;
      logic [CNT_W-1:0] addr;
      logic [CNT_W-1:0] data;
   } ord_wr_type;

endpackage

`default_nettype wire

// ===== src/permen_store.sv =====
// Symbol store with one indexed read and a duplicate detector over the active slots.
`default_nettype none

module permen_store #(
   parameter int MAX_SYMBOLS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [permen_pkg::SLOT_W-1:0] wr_slot,
   input  wire logic [permen_pkg::SYM_W-1:0]  wr_symbol,
   input  wire logic [permen_pkg::CNT_W-1:0]  rd_addr,
   output logic      [permen_pkg::SYM_W-1:0]  rd_symbol,
   input  wire logic [permen_pkg::CNT_W-1:0]  n_last,
   output logic                               dup
);

   localparam int LIM = (MAX_SYMBOLS < 8) ? MAX_SYMBOLS : 8;
   localparam int SAW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

   logic [permen_pkg::SYM_W-1:0] sym_ff [MAX_SYMBOLS];
   logic [4:0] slot_ext;
   logic       slot_ok;

   assign slot_ext = 5'(wr_slot);
   assign slot_ok  = slot_ext < 5'(MAX_SYMBOLS);

   always_ff @(posedge clock) begin
      if (wr_en && slot_ok) begin
         sym_ff[SAW'(wr_slot)] <= wr_symbol;
      end
   end

   assign rd_symbol = sym_ff[SAW'(rd_addr)];

   always_comb begin
      dup = 1'b0;
      for (int i = 0; i < LIM; i++) begin
         for (int j = i + 1; j < LIM; j++) begin
            if ((permen_pkg::CNT_W'(j) <= n_last) && (sym_ff[i] == sym_ff[j])) begin
               dup = 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/permen_ordfile.sv =====
// Index order register file: one read port, one write port, restart to identity order.
`default_nettype none

module permen_ordfile #(
   parameter int MAX_SYMBOLS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         restart,
   input  wire permen_pkg::ord_wr_type       wr,
   input  wire logic [permen_pkg::CNT_W-1:0] rd_addr,
   output logic      [permen_pkg::CNT_W-1:0] rd_data
);

   localparam int LIM   = (MAX_SYMBOLS < 8) ? MAX_SYMBOLS : 8;
   localparam int VAL_W = (LIM > 1) ? $clog2(LIM) : 1;

   logic [VAL_W-1:0] ord_ff [LIM];

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int i = 0; i < LIM; i++) begin
            ord_ff[i] <= VAL_W'(i);
         end
      end else if (wr.we) begin
         ord_ff[wr.addr[VAL_W-1:0]] <= wr.data[VAL_W-1:0];
      end
   end

   assign rd_data = permen_pkg::CNT_W'(ord_ff[rd_addr[VAL_W-1:0]]);

endmodule

`default_nettype wire

// ===== src/permen_ctrl.sv =====
// Sequencer with the shared comparator, size register and result register.
`default_nettype none

module permen_ctrl #(
   parameter int MAX_SYMBOLS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_op,
   output logic                               load_we,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [permen_pkg::SIZE_W-1:0] csr_data,
   output logic      [permen_pkg::CNT_W-1:0]  n_last,
   input  wire logic                          dup,
   output logic      [permen_pkg::CNT_W-1:0]  rd_addr,
   input  wire logic [permen_pkg::CNT_W-1:0]  rd_val,
   input  wire logic [permen_pkg::SYM_W-1:0]  sym_val,
   output permen_pkg::ord_wr_type             ord_wr,
   output logic                               restart,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [permen_pkg::SYM_W-1:0]  rsp_symbol_out,
   output logic      [permen_pkg::CNT_W-1:0]  rsp_position,
   output logic                               rsp_last,
   output logic                               rsp_final_perm,
   output logic                               rsp_empty_res
);

   localparam int LIM = (MAX_SYMBOLS < 8) ? MAX_SYMBOLS : 8;
   localparam int CW  = permen_pkg::CNT_W;
   localparam int SW  = permen_pkg::SIZE_W;

   permen_pkg::state_type state_ff, state_in;
   logic [SW-1:0] set_size_ff, set_size_in;
   logic          exh_ff, exh_in;
   logic          nopiv_ff, nopiv_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] p_ff, p_in;
   logic [CW-1:0] pv_ff, pv_in;
   logic [CW-1:0] aux_ff, aux_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [permen_pkg::SYM_W-1:0] rsp_sym_ff, rsp_sym_in;
   logic [CW-1:0] rsp_pos_ff, rsp_pos_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_final_ff, rsp_final_in;
   logic          rsp_empty_ff, rsp_empty_in;

   logic [SW-1:0] n_eff, n_eff_m1;
   logic          acc, cfg_we, out_free, lt;
   logic [CW-1:0] cmp_a, cmp_b;
   logic [CW-1:0] cnt_inc, cnt_dec, hi_dec, p_inc;

   always_comb begin
      if (set_size_ff == '0) begin
         n_eff = SW'(1);
      end else if (set_size_ff > SW'(LIM)) begin
         n_eff = SW'(LIM);
      end else begin
         n_eff = set_size_ff;
      end
   end

   assign n_eff_m1 = n_eff - SW'(1);
   assign n_last   = n_eff_m1[CW-1:0];

   assign req_stall = (state_ff != permen_pkg::ST_IDLE);
   assign csr_ready = (state_ff == permen_pkg::ST_IDLE);
   assign acc       = req_valid && !req_stall;
   assign cfg_we    = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign cnt_inc = cnt_ff + CW'(1);
   assign cnt_dec = cnt_ff - CW'(1);
   assign hi_dec  = hi_ff - CW'(1);
   assign p_inc   = p_ff + CW'(1);

   // shared comparator: pivot scan tests a[i] < a[i+1], successor search tests a[p] < a[j]
   assign cmp_a = (state_ff == permen_pkg::ST_FIND) ? pv_ff : rd_val;
   assign cmp_b = (state_ff == permen_pkg::ST_FIND) ? rd_val : aux_ff;
   assign lt    = cmp_a < cmp_b;

   always_comb begin
      state_in     = state_ff;
      set_size_in  = set_size_ff;
      exh_in       = exh_ff;
      nopiv_in     = nopiv_ff;
      cnt_in       = cnt_ff;
      hi_in        = hi_ff;
      p_in         = p_ff;
      pv_in        = pv_ff;
      aux_in       = aux_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_sym_in   = rsp_sym_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_final_in = rsp_final_ff;
      rsp_empty_in = rsp_empty_ff;
      rd_addr      = cnt_ff;
      ord_wr       = '0;
      restart      = 1'b0;
      load_we      = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cfg_we) begin
         set_size_in = csr_data;
         restart     = 1'b1;
         exh_in      = 1'b0;
      end

      unique case (state_ff)
         permen_pkg::ST_IDLE: begin
            if (acc) begin
               if (req_op == permen_pkg::OP_LOAD) begin
                  load_we = 1'b1;
                  restart = 1'b1;
                  exh_in  = 1'b0;
               end else if (exh_ff || dup) begin
                  state_in = permen_pkg::ST_EMPTY;
               end else begin
                  cnt_in   = n_last;
                  state_in = permen_pkg::ST_PIVOT;
               end
            end
         end
         permen_pkg::ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sym_in   = '0;
               rsp_pos_in   = '0;
               rsp_last_in  = 1'b1;
               rsp_final_in = 1'b0;
               rsp_empty_in = 1'b1;
               state_in     = permen_pkg::ST_IDLE;
            end
         end
         permen_pkg::ST_PIVOT: begin
            if ((cnt_ff != n_last) && lt) begin
               p_in     = cnt_ff;
               pv_in    = rd_val;
               nopiv_in = 1'b0;
               cnt_in   = '0;
               state_in = permen_pkg::ST_EMIT;
            end else begin
               aux_in = rd_val;
               if (cnt_ff == '0) begin
                  nopiv_in = 1'b1;
                  state_in = permen_pkg::ST_EMIT;
               end else begin
                  cnt_in = cnt_dec;
               end
            end
         end
         permen_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sym_in   = sym_val;
               rsp_pos_in   = cnt_ff;
               rsp_last_in  = (cnt_ff == n_last);
               rsp_final_in = nopiv_ff;
               rsp_empty_in = 1'b0;
               if (cnt_ff == n_last) begin
                  if (nopiv_ff) begin
                     exh_in   = 1'b1;
                     state_in = permen_pkg::ST_IDLE;
                  end else begin
                     cnt_in   = n_last;
                     state_in = permen_pkg::ST_FIND;
                  end
               end else begin
                  cnt_in = cnt_inc;
               end
            end
         end
         permen_pkg::ST_FIND: begin
            if (lt) begin
               aux_in   = rd_val;
               hi_in    = cnt_ff;
               state_in = permen_pkg::ST_SWAP1;
            end else begin
               cnt_in = cnt_dec;
            end
         end
         permen_pkg::ST_SWAP1: begin
            ord_wr.we   = 1'b1;
            ord_wr.addr = p_ff;
            ord_wr.data = aux_ff;
            state_in    = permen_pkg::ST_SWAP2;
         end
         permen_pkg::ST_SWAP2: begin
            ord_wr.we   = 1'b1;
            ord_wr.addr = hi_ff;
            ord_wr.data = pv_ff;
            cnt_in      = p_inc;
            hi_in       = n_last;
            state_in    = (p_inc < n_last) ? permen_pkg::ST_REVA : permen_pkg::ST_IDLE;
         end
         permen_pkg::ST_REVA: begin
            aux_in   = rd_val;
            state_in = permen_pkg::ST_REVB;
         end
         permen_pkg::ST_REVB: begin
            rd_addr     = hi_ff;
            ord_wr.we   = 1'b1;
            ord_wr.addr = cnt_ff;
            ord_wr.data = rd_val;
            state_in    = permen_pkg::ST_REVC;
         end
         permen_pkg::ST_REVC: begin
            ord_wr.we   = 1'b1;
            ord_wr.addr = hi_ff;
            ord_wr.data = aux_ff;
            cnt_in      = cnt_inc;
            hi_in       = hi_dec;
            state_in    = (cnt_inc < hi_dec) ? permen_pkg::ST_REVA : permen_pkg::ST_IDLE;
         end
         default: begin
            state_in = permen_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= permen_pkg::ST_IDLE;
         set_size_ff  <= permen_pkg::SIZE_RESET;
         exh_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         set_size_ff  <= set_size_in;
         exh_ff       <= exh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nopiv_ff     <= nopiv_in;
      cnt_ff       <= cnt_in;
      hi_ff        <= hi_in;
      p_ff         <= p_in;
      pv_ff        <= pv_in;
      aux_ff       <= aux_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_final_ff <= rsp_final_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_symbol_out = rsp_sym_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_final_perm = rsp_final_ff;
   assign rsp_empty_res  = rsp_empty_ff;

`ifndef NO_ASSERTIONS
   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_last_ff && !rsp_final_ff && (rsp_pos_ff == '0))
      else $error("empty item malformed");

   a_next_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      acc && (req_op == permen_pkg::OP_NEXT) |=> state_ff != permen_pkg::ST_IDLE)
      else $error("next request did not start the sequencer");

   a_ord_write_states: assert property (@(posedge clock) disable iff (reset)
      ord_wr.we |-> (state_ff == permen_pkg::ST_SWAP1) || (state_ff == permen_pkg::ST_SWAP2)
                    || (state_ff == permen_pkg::ST_REVB) || (state_ff == permen_pkg::ST_REVC))
      else $error("index order written outside the advance");

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == permen_pkg::ST_EMIT |-> cnt_ff <= n_last)
      else $error("emit position beyond set size");

   a_last_ends_perm: assert property (@(posedge clock) disable iff (reset)
      state_ff == permen_pkg::ST_EMIT && out_free && (cnt_ff == n_last)
      |=> rsp_valid_ff && rsp_last_ff && (state_ff != permen_pkg::ST_EMIT))
      else $error("last item did not close the permutation");
`endif

endmodule

`default_nettype wire

// ===== src/permutation_enumerator_core.sv =====
// Top level of the lexicographic permutation enumerator.
//
//   channel  dir  ports                                         handshake
//   req      in   req_op, req_slot, req_symbol                  req_valid & !req_stall
//   rsp      out  rsp_symbol_out, rsp_position, rsp_last,       rsp_valid & !rsp_stall
//                 rsp_final_perm, rsp_empty_res
//   csr      in   csr_data (set size)                           csr_valid & csr_ready
//
// A load is taken in the idle state. A next request with n active symbols runs the
// pivot scan, emission of the n items, the successor search, the swap in SWAP1 and
// SWAP2 and the reversal in REVA, REVB and REVC per pair, one step at a time as set
// by the single read port of the index order file and the one shared comparator;
// the final permutation skips search, swap, reversal; ST_EMPTY sends an empty item.
// Reset is synchronous: index order back to identity, set size 4, no clearing pass.
// A stalled result holds the sequencer in emission or in the empty state; requests
// and size writes are still taken while the last result item waits.
`default_nettype none

module permutation_enumerator_core #(
   parameter int MAX_SYMBOLS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_op,
   input  wire logic [permen_pkg::SLOT_W-1:0] req_slot,
   input  wire logic [permen_pkg::SYM_W-1:0]  req_symbol,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [permen_pkg::SYM_W-1:0]  rsp_symbol_out,
   output logic      [permen_pkg::CNT_W-1:0]  rsp_position,
   output logic                               rsp_last,
   output logic                               rsp_final_perm,
   output logic                               rsp_empty_res,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [permen_pkg::SIZE_W-1:0] csr_data
);

   logic                           load_we;
   logic                           dup;
   logic                           restart;
   logic [permen_pkg::CNT_W-1:0]   n_last;
   logic [permen_pkg::CNT_W-1:0]   rd_addr;
   logic [permen_pkg::CNT_W-1:0]   rd_val;
   logic [permen_pkg::SYM_W-1:0]   sym_val;
   permen_pkg::ord_wr_type         ord_wr;

   permen_store #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_store (
      .clock     (clock),
      .wr_en     (load_we),
      .wr_slot   (req_slot),
      .wr_symbol (req_symbol),
      .rd_addr   (rd_val),
      .rd_symbol (sym_val),
      .n_last    (n_last),
      .dup       (dup)
   );

   permen_ordfile #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_ordfile (
      .clock   (clock),
      .reset   (reset),
      .restart (restart),
      .wr      (ord_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_val)
   );

   permen_ctrl #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .load_we        (load_we),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .n_last         (n_last),
      .dup            (dup),
      .rd_addr        (rd_addr),
      .rd_val         (rd_val),
      .sym_val        (sym_val),
      .ord_wr         (ord_wr),
      .restart        (restart),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_symbol_out (rsp_symbol_out),
      .rsp_position   (rsp_position),
      .rsp_last       (rsp_last),
      .rsp_final_perm (rsp_final_perm),
      .rsp_empty_res  (rsp_empty_res)
   );

endmodule

`default_nettype wire

// ===== bench/permutation_enumerator_core_test.sv =====
// Self-checking bench for the permutation enumerator: random and directed items against a predictor.
`default_nettype none

module permutation_enumerator_core_test;

   localparam int SLOT_W      = permen_pkg::SLOT_W;
   localparam int SYM_W       = permen_pkg::SYM_W;
   localparam int CNT_W       = permen_pkg::CNT_W;
   localparam int SIZE_W      = permen_pkg::SIZE_W;
   localparam int MAX_SYM     = 8;
   localparam int CYCLE_LIMIT = 500000;
   localparam int NUM_PHASES  = 9;

   typedef struct {
      logic              op;
      logic [SLOT_W-1:0] slot;
      logic [SYM_W-1:0]  symbol;
      bit                wait_drain;
   } req_item_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic [CNT_W-1:0] position;
      logic             last;
      logic             final_perm;
      logic             empty_res;
   } perm_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_op = permen_pkg::OP_LOAD;
   logic [SLOT_W-1:0] req_slot = '0;
   logic [SYM_W-1:0]  req_symbol = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [SYM_W-1:0]  rsp_symbol_out;
   logic [CNT_W-1:0]  rsp_position;
   logic              rsp_last;
   logic              rsp_final_perm;
   logic              rsp_empty_res;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [SIZE_W-1:0] csr_data = '0;

   permutation_enumerator_core #(.MAX_SYMBOLS(MAX_SYM)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_op(req_op), .req_slot(req_slot), .req_symbol(req_symbol),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_symbol_out(rsp_symbol_out), .rsp_position(rsp_position),
      .rsp_last(rsp_last), .rsp_final_perm(rsp_final_perm),
      .rsp_empty_res(rsp_empty_res),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [SYM_W-1:0]  sym_store [MAX_SYM];
   logic [CNT_W-1:0]  order     [MAX_SYM];
   bit                exhausted_flag;
   logic [SIZE_W-1:0] size_reg;

   req_item_type  pending_items[$];
   perm_item_type expected_perm_items[$];
   logic [SYM_W-1:0] gen_store [MAX_SYM];
   int            gen_count = 0;
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            send_idle_pct = 38;
   int            recv_idle_pct = 64;
   bit            req_taken = 1'b0;
   req_item_type  next_req;
   perm_item_type seen_item;
   perm_item_type want_item;
   logic [SIZE_W-1:0] phase_sizes [NUM_PHASES] =
      '{4'd4, 4'd2, 4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd5, 4'd0};

   function automatic int clamp_size(logic [SIZE_W-1:0] value);
      int n;
      n = value;
      if (n < 1) n = 1;
      if (n > MAX_SYM) n = MAX_SYM;
      return n;
   endfunction

   function automatic void restart_order();
      for (int i = 0; i < MAX_SYM; i++) order[i] = i[CNT_W-1:0];
      exhausted_flag = 0;
   endfunction

   function automatic void compute_permutation(logic op, logic [SLOT_W-1:0] slot,
                                               logic [SYM_W-1:0] symbol);
      int n, p, j, lo, hi;
      bit dup;
      logic [CNT_W-1:0] t;
      perm_item_type r;
      if (op == permen_pkg::OP_LOAD) begin
         sym_store[slot] = symbol;
         restart_order();
         return;
      end
      n = clamp_size(size_reg);
      dup = 0;
      for (int a = 0; a < n; a++)
         for (int b = a + 1; b < n; b++)
            if (sym_store[a] == sym_store[b]) dup = 1;
      if (exhausted_flag || dup) begin
         r = '{symbol: '0, position: '0, last: 1'b1, final_perm: 1'b0, empty_res: 1'b1};
         expected_perm_items.insert(expected_perm_items.size(), r);
         return;
      end
      p = -1;
      for (int i = 0; i < n - 1; i++)
         if (order[i] < order[i + 1]) p = i;
      for (int k = 0; k < n; k++) begin
         r.symbol     = sym_store[order[k]];
         r.position   = k[CNT_W-1:0];
         r.last       = (k == n - 1);
         r.final_perm = (p < 0);
         r.empty_res  = 1'b0;
         expected_perm_items.insert(expected_perm_items.size(), r);
      end
      if (p < 0) begin
         exhausted_flag = 1;
      end else begin
         j = n - 1;
         while (order[j] <= order[p]) j--;
         t = order[p]; order[p] = order[j]; order[j] = t;
         lo = p + 1;
         hi = n - 1;
         while (lo < hi) begin
            t = order[lo]; order[lo] = order[hi]; order[hi] = t;
            lo++;
            hi--;
         end
      end
   endfunction

   task automatic log_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   function automatic void add_item(logic op, logic [SLOT_W-1:0] slot,
                                    logic [SYM_W-1:0] symbol, bit drain);
      req_item_type it;
      it = '{op: op, slot: slot, symbol: symbol, wait_drain: drain};
      pending_items.insert(pending_items.size(), it);
      if (op == permen_pkg::OP_LOAD) gen_store[slot] = symbol;
      gen_count++;
   endfunction

   task automatic fill_random(input int n, input int target);
      int start, k_max, a, b, r;
      logic [SYM_W-1:0] v;
      bit fresh;
      start = gen_count;
      k_max = (n == 1) ? 3 : (n == 2) ? 4 : (n == 3) ? 8 : 12;
      while (gen_count - start < target) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            if ($urandom_range(0, 1)) begin
               for (a = 0; a < n; a++) begin
                  do begin
                     v = SYM_W'($urandom_range(0, 255));
                     fresh = 1;
                     for (b = 0; b < a; b++) if (gen_store[b] == v) fresh = 0;
                  end while (!fresh);
                  add_item(permen_pkg::OP_LOAD, a[SLOT_W-1:0], v, 1'b0);
               end
            end
            repeat ($urandom_range(1, k_max))
               add_item(permen_pkg::OP_NEXT, SLOT_W'($urandom_range(0, 7)),
                        SYM_W'($urandom_range(0, 255)), $urandom_range(0, 99) < 3);
         end else if (r < 85 && n > 1) begin
            a = $urandom_range(0, n - 2);
            b = $urandom_range(a + 1, n - 1);
            add_item(permen_pkg::OP_LOAD, b[SLOT_W-1:0], gen_store[a], 1'b0);
            repeat ($urandom_range(1, 3))
               add_item(permen_pkg::OP_NEXT, SLOT_W'($urandom_range(0, 7)),
                        SYM_W'($urandom_range(0, 255)), 1'b0);
         end else begin
            add_item(1'($urandom_range(0, 1)), SLOT_W'($urandom_range(0, 7)),
                     SYM_W'($urandom_range(0, 255)), 1'b0);
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || expected_perm_items.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      size_reg = value;
      restart_order();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("permutation_enumerator_core_test: done, errors");
         $finish;
      end
   end

   // acceptance and result check
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) compute_permutation(req_op, req_slot, req_symbol);
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_item = '{rsp_symbol_out, rsp_position, rsp_last, rsp_final_perm, rsp_empty_res};
         if (expected_perm_items.size() == 0) begin
            log_mismatch($sformatf("unexpected item sym=%0h pos=%0d", rsp_symbol_out,
                                   rsp_position));
         end else begin
            want_item = expected_perm_items.pop_front();
            if (seen_item !== want_item)
               log_mismatch($sformatf(
                  "got sym=%0h pos=%0d last=%0b final=%0b empty=%0b, want %0h %0d %0b %0b %0b",
                  seen_item.symbol, seen_item.position, seen_item.last,
                  seen_item.final_perm, seen_item.empty_res,
                  want_item.symbol, want_item.position, want_item.last,
                  want_item.final_perm, want_item.empty_res));
         end
      end
   end

   // driver
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_items.size() != 0 &&
             !(pending_items[0].wait_drain && expected_perm_items.size() != 0) &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            next_req = pending_items.pop_front();
            req_valid  <= 1'b1;
            req_op     <= next_req.op;
            req_slot   <= next_req.slot;
            req_symbol <= next_req.symbol;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   initial begin
      int phase;
      size_reg = permen_pkg::SIZE_RESET;
      for (int i = 0; i < MAX_SYM; i++) begin
         sym_store[i] = '0;
         gen_store[i] = '0;
      end
      restart_order();
      phase_sizes[NUM_PHASES - 1] = SIZE_W'($urandom_range(0, 15));
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) write_size(phase_sizes[phase]);
         send_idle_pct = (phase < 3) ? 38 : (phase < 6) ? 64 : 0;
         recv_idle_pct = (phase < 3) ? 64 : (phase < 6) ? 38 : 0;
         if (phase == 0) begin
            add_item(permen_pkg::OP_LOAD, 3'd0, 8'h00, 1'b0);
            add_item(permen_pkg::OP_LOAD, 3'd1, 8'hFF, 1'b0);
            add_item(permen_pkg::OP_LOAD, 3'd2, 8'h55, 1'b0);
            add_item(permen_pkg::OP_LOAD, 3'd3, 8'hAA, 1'b0);
            add_item(permen_pkg::OP_LOAD, 3'd4, 8'h01, 1'b0);
            add_item(permen_pkg::OP_LOAD, 3'd5, 8'h02, 1'b0);
            add_item(permen_pkg::OP_LOAD, 3'd6, 8'h03, 1'b0);
            add_item(permen_pkg::OP_LOAD, 3'd7, 8'h7F, 1'b0);
            repeat (3) add_item(permen_pkg::OP_NEXT, 3'd0, 8'h00, 1'b0);
            // duplicate in the active set, sent only once all results are in
            add_item(permen_pkg::OP_LOAD, 3'd2, 8'h00, 1'b1);
            repeat (2) add_item(permen_pkg::OP_NEXT, 3'd7, 8'hFF, 1'b0);
            add_item(permen_pkg::OP_LOAD, 3'd2, 8'h55, 1'b0);
            add_item(permen_pkg::OP_NEXT, 3'd0, 8'h00, 1'b0);
         end else begin
            if (phase == 1) begin
               // run past the final order into exhaustion, then restart by a load
               repeat (4) add_item(permen_pkg::OP_NEXT, 3'd0, 8'h00, 1'b0);
               add_item(permen_pkg::OP_LOAD, 3'd1, 8'hFF, 1'b0);
               add_item(permen_pkg::OP_NEXT, 3'd0, 8'h00, 1'b0);
            end
            fill_random(clamp_size(phase_sizes[phase]), 42);
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("permutation_enumerator_core_test: done, clean");
      end else begin
         $display("permutation_enumerator_core_test: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== permutation_enumerator_core.f =====
src/permen_pkg.sv
src/permen_store.sv
src/permen_ordfile.sv
src/permen_ctrl.sv
src/permutation_enumerator_core.sv
bench/permutation_enumerator_core_test.sv
